// File: design/heap_sort_key_tag_unit_macros.svh
// Assertion macros for the heap sort key/tag unit checker.
// Included by the checker file only; no other dependencies.
`ifndef HEAP_SORT_KEY_TAG_UNIT_MACROS_SVH
`define HEAP_SORT_KEY_TAG_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define HSTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HSTK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/hstk_pkg.sv
// Shared types and constants for the heap sort key/tag unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package hstk_pkg;

  localparam int HSTK_DEPTH = 1024;
  localparam int KEY_W      = 32;
  localparam int TAG_W      = 16;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic        [TAG_W-1:0] tag_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

endpackage

`default_nettype wire

// File: design/heap_sort_key_tag_unit.sv
// Top level of the heap sort key/tag unit: load/read control and heapsort sequencer.
// Depends on hstk_pkg, hstk_mem and hstk_cmp.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall  | in_mode, in_key_in, in_tag_in, in_final_load
//  out     | output    | out_valid/out_stall| out_key_out, out_tag_out, out_final_out,
//          |           |                    | out_empty_res
//
// A load item writes the store directly; a read item of a sorted set goes through the
// registered memory read. A final load of n >= 2 pairs runs the heapsort on the single
// memory and the single comparator, one sift level at a time. in_stall is high while
// sorting, during a read, and while a result waits in the output register. Reset is
// synchronous, active low; the store needs no clearing.
`default_nettype none

module heap_sort_key_tag_unit
  import hstk_pkg::*;
#(
  parameter int DEPTH = HSTK_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic in_mode,
  input  wire key_t in_key_in,
  input  wire tag_t in_tag_in,
  input  wire logic in_final_load,

  output logic      out_valid,
  input  wire logic out_stall,
  output key_t      out_key_out,
  output tag_t      out_tag_out,
  output logic      out_final_out,
  output logic      out_empty_res
);

  localparam int NW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = NW + 1;
  localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
  localparam logic [NW-1:0] ONE_N   = NW'(1);
  localparam logic [NW-1:0] TWO_N   = NW'(2);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_NEXT, S_LDK, S_EX1, S_EX2, S_FIN, S_SIFT, S_C1, S_C2, S_C3
  } state_t;

  state_t          state_r;
  logic [NW-1:0]   cnt_r, rp_r, top_r, last_r, hole_r;
  logic [CW-1:0]   child_r;
  logic            sorted_r;
  entry_t          k_r, cand_r;
  logic            out_valid_r, out_final_r, out_empty_r;
  key_t            out_key_r;
  tag_t            out_tag_r;

  logic            in_acc;
  logic [NW-1:0]   eff_cnt, new_cnt, top_m2, last_m1, hole_m1;
  logic [CW-1:0]   child_m1, last_x;
  logic            room;

  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  entry_t          wr_data, rd_data, in_entry;
  key_t            cmp_a, cmp_b;
  logic            cmp_lt;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_acc   = in_valid && !in_stall;

  // a load after a sort opens a new set
  assign eff_cnt  = sorted_r ? '0 : cnt_r;
  assign room     = (eff_cnt < DEPTH_N);
  assign new_cnt  = room ? eff_cnt + ONE_N : eff_cnt;
  assign top_m2   = top_r - TWO_N;
  assign last_m1  = last_r - ONE_N;
  assign hole_m1  = hole_r - ONE_N;
  assign child_m1 = child_r - CW'(1);
  assign last_x   = {1'b0, last_r};
  assign in_entry = '{key: in_key_in, tag: in_tag_in};

  hstk_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hstk_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  always_comb begin
    cmp_a = k_r.key;
    cmp_b = cand_r.key;
    if (state_r == S_C2) begin
      cmp_a = cand_r.key;
      cmp_b = rd_data.key;
    end
  end

  always_comb begin
    rd_addr = rp_r[AW-1:0];
    unique case (state_r)
      S_NEXT:  rd_addr = (top_r > ONE_N) ? top_m2[AW-1:0] : last_m1[AW-1:0];
      S_EX1:   rd_addr = '0;
      S_SIFT:  rd_addr = child_m1[AW-1:0];
      S_C1:    rd_addr = child_r[AW-1:0];
      default: rd_addr = rp_r[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hole_m1[AW-1:0];
    wr_data = k_r;
    unique case (state_r)
      S_IDLE: begin
        wr_en   = in_acc && (in_mode == MODE_LOAD) && room;
        wr_addr = eff_cnt[AW-1:0];
        wr_data = in_entry;
      end
      S_EX2: begin
        wr_en   = 1'b1;
        wr_addr = last_m1[AW-1:0];
        wr_data = rd_data;
      end
      S_FIN: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      S_SIFT: begin
        wr_en = (child_r > last_x);
      end
      S_C3: begin
        wr_en   = 1'b1;
        wr_data = cmp_lt ? cand_r : k_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rp_r        <= '0;
      sorted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_mode == MODE_LOAD) begin
              cnt_r <= new_cnt;
              if (in_final_load) begin
                rp_r     <= '0;
                sorted_r <= 1'b1;
                if (new_cnt >= TWO_N) begin
                  top_r   <= (new_cnt >> 1) + ONE_N;
                  last_r  <= new_cnt;
                  state_r <= S_NEXT;
                end
              end else if (sorted_r) begin
                rp_r     <= '0;
                sorted_r <= 1'b0;
              end
            end else if (sorted_r && (rp_r < cnt_r)) begin
              state_r <= S_RD;
            end else begin
              out_valid_r <= 1'b1;
              out_key_r   <= '0;
              out_tag_r   <= '0;
              out_final_r <= 1'b0;
              out_empty_r <= 1'b1;
            end
          end
        end
        S_RD: begin
          out_valid_r <= 1'b1;
          out_key_r   <= rd_data.key;
          out_tag_r   <= rd_data.tag;
          out_final_r <= ((rp_r + ONE_N) == cnt_r);
          out_empty_r <= 1'b0;
          rp_r        <= rp_r + ONE_N;
          state_r     <= S_IDLE;
        end
        S_NEXT: begin
          // build phase while top > 1, extraction phase afterwards
          if (top_r > ONE_N) begin
            top_r   <= top_r - ONE_N;
            state_r <= S_LDK;
          end else begin
            state_r <= S_EX1;
          end
        end
        S_LDK: begin
          k_r     <= rd_data;
          hole_r  <= top_r;
          child_r <= {top_r, 1'b0};
          state_r <= S_SIFT;
        end
        S_EX1: begin
          k_r     <= rd_data;
          state_r <= S_EX2;
        end
        S_EX2: begin
          last_r <= last_m1;
          if (last_m1 == ONE_N) begin
            state_r <= S_FIN;
          end else begin
            hole_r  <= top_r;
            child_r <= {top_r, 1'b0};
            state_r <= S_SIFT;
          end
        end
        S_FIN: begin
          state_r <= S_IDLE;
        end
        S_SIFT: begin
          state_r <= (child_r <= last_x) ? S_C1 : S_NEXT;
        end
        S_C1: begin
          cand_r  <= rd_data;
          state_r <= (child_r < last_x) ? S_C2 : S_C3;
        end
        S_C2: begin
          // right child wins only if strictly greater
          if (cmp_lt) begin
            cand_r  <= rd_data;
            child_r <= child_r + CW'(1);
          end
          state_r <= S_C3;
        end
        S_C3: begin
          if (cmp_lt) begin
            hole_r  <= child_r[NW-1:0];
            child_r <= {child_r[NW-1:0], 1'b0};
            state_r <= S_SIFT;
          end else begin
            state_r <= S_NEXT;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_out   = out_key_r;
  assign out_tag_out   = out_tag_r;
  assign out_final_out = out_final_r;
  assign out_empty_res = out_empty_r;

endmodule

`default_nettype wire

// File: design/hstk_mem.sv
// Key/tag store: one write port, one read port with registered read data.
// Depends on hstk_pkg for the entry type.
`default_nettype none

module hstk_mem
  import hstk_pkg::*;
#(
  parameter int DEPTH = HSTK_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: design/hstk_cmp.sv
// Shared signed key comparator used by every sift step.
// Depends on hstk_pkg for the key type.
`default_nettype none

module hstk_cmp
  import hstk_pkg::*;
(
  input  wire key_t a,
  input  wire key_t b,
  output logic      lt
);

  assign lt = (a < b);

endmodule

`default_nettype wire

// File: design/hstk_chk.sv
// Port-level checker for the heap sort key/tag unit, bound to the top level.
// Depends on hstk_pkg and heap_sort_key_tag_unit_macros.svh.
`default_nettype none
`include "heap_sort_key_tag_unit_macros.svh"

module hstk_chk
  import hstk_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic in_mode,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire key_t out_key_out,
  input wire tag_t out_tag_out,
  input wire logic out_final_out,
  input wire logic out_empty_res
);

  // a waiting result holds until taken
  `HSTK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_key_out) && $stable(out_tag_out) && $stable(out_final_out) && $stable(out_empty_res), "result changed while stalled")

  // an empty result carries no pair
  `HSTK_ASSERT(a_empty_zero, out_valid && out_empty_res |-> out_key_out == '0 && out_tag_out == '0 && !out_final_out, "empty result with data")

  // any accepted read item blocks the input until its result is out
  `HSTK_ASSERT(a_read_blocks, in_valid && !in_stall && in_mode == MODE_READ |=> in_stall, "read accepted without stall")

  // no result can appear from reset
  `HSTK_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result after reset")

endmodule

bind heap_sort_key_tag_unit hstk_chk u_hstk_chk (.*);

`default_nettype wire

// File: tb/heap_sort_key_tag_unit_tb.sv
// Testbench for heap_sort_key_tag_unit: loads key/tag sets, lets the block sort them and
// reads them back, checking every read result against a heapsort kept in a scoreboard class.
// Depends on hstk_pkg and the heap_sort_key_tag_unit RTL.
`timescale 1ns / 1ps

module heap_sort_key_tag_unit_tb;
  import hstk_pkg::*;

  localparam int   IDLE_LIMIT   = 400000;
  localparam int   BIG_SET      = 100;
  localparam int   RANDOM_ITEMS = 320;
  localparam key_t KEY_MIN      = 32'sh8000_0000;
  localparam key_t KEY_MAX      = 32'sh7FFF_FFFF;

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last;
    logic empty;
  } pair_result_t;

  // Keeps its own copy of the store, sorts it the same way the block does and
  // queues one expected result per read item.
  class pair_scoreboard;
    key_t           key_mem[HSTK_DEPTH];
    tag_t           tag_mem[HSTK_DEPTH];
    int unsigned    held;
    int unsigned    next_rd;
    bit             sorted;
    pair_result_t   want_q[$];
    int unsigned    mismatches;
    int unsigned    checked;
    int unsigned    empties;
    int unsigned    sorts;

    function new();
      held       = 0;
      next_rd    = 0;
      sorted     = 0;
      mismatches = 0;
      checked    = 0;
      empties    = 0;
      sorts      = 0;
    endfunction

    // Positions 1..n live at index pos-1; strict compares decide the order of equal keys.
    function void heapsort_store(int unsigned n);
      int unsigned top;
      int unsigned last;
      int unsigned hole;
      int unsigned child;
      key_t        k;
      tag_t        t;
      if (n < 2 || n > HSTK_DEPTH) return;
      top  = (n >> 1) + 1;
      last = n;
      forever begin
        if (top > 1) begin
          top--;
          k = key_mem[top-1];
          t = tag_mem[top-1];
        end else begin
          k = key_mem[last-1];
          t = tag_mem[last-1];
          key_mem[last-1] = key_mem[0];
          tag_mem[last-1] = tag_mem[0];
          last--;
          if (last == 1) begin
            key_mem[0] = k;
            tag_mem[0] = t;
            return;
          end
        end
        hole  = top;
        child = top << 1;
        while (child <= last) begin
          if (child < last && key_mem[child-1] < key_mem[child]) child++;
          if (k < key_mem[child-1]) begin
            key_mem[hole-1] = key_mem[child-1];
            tag_mem[hole-1] = tag_mem[child-1];
            hole  = child;
            child = child << 1;
          end else begin
            break;
          end
        end
        key_mem[hole-1] = k;
        tag_mem[hole-1] = t;
      end
    endfunction

    function void note_item(logic mode, key_t key, tag_t tag, logic fin);
      pair_result_t r;
      if (mode == MODE_LOAD) begin
        // first load after a sort opens a new set
        if (sorted) begin
          held    = 0;
          next_rd = 0;
          sorted  = 0;
        end
        if (held < HSTK_DEPTH) begin
          key_mem[held] = key;
          tag_mem[held] = tag;
          held++;
        end
        if (fin) begin
          heapsort_store(held);
          next_rd = 0;
          sorted  = 1;
          sorts++;
        end
      end else begin
        if (sorted && next_rd < held) begin
          r.key   = key_mem[next_rd];
          r.tag   = tag_mem[next_rd];
          r.last  = (next_rd + 1 == held);
          r.empty = 1'b0;
          next_rd++;
        end else begin
          r = '{key: '0, tag: '0, last: 1'b0, empty: 1'b1};
        end
        want_q.push_back(r);
      end
    endfunction

    function void check_result(pair_result_t got);
      pair_result_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: result with nothing pending, key %0d tag %h final %b empty %b",
                   $signed(got.key), got.tag, got.last, got.empty);
        return;
      end
      want = want_q.pop_front();
      checked++;
      if (want.empty) empties++;
      if (got.key !== want.key || got.tag !== want.tag || got.last !== want.last ||
          got.empty !== want.empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch #%0d: exp key %0d tag %h final %b empty %b,",
                    " got key %0d tag %h final %b empty %b"},
                   checked, $signed(want.key), want.tag, want.last, want.empty,
                   $signed(got.key), got.tag, got.last, got.empty);
      end
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction
  endclass

  logic clk           = 1'b0;
  logic rst_n         = 1'b0;
  logic in_valid      = 1'b0;
  logic in_stall;
  logic in_mode       = MODE_LOAD;
  key_t in_key_in     = '0;
  tag_t in_tag_in     = '0;
  logic in_final_load = 1'b0;
  logic out_valid;
  logic out_stall     = 1'b0;
  key_t out_key_out;
  tag_t out_tag_out;
  logic out_final_out;
  logic out_empty_res;

  pair_scoreboard sb;
  bit             in_burst   = 1'b0;
  bit             out_burst  = 1'b0;
  int unsigned    load_count = 0;
  int unsigned    read_count = 0;
  int unsigned    idle_cycles = 0;

  heap_sort_key_tag_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_key_in     (in_key_in),
    .in_tag_in     (in_tag_in),
    .in_final_load (in_final_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key_out   (out_key_out),
    .out_tag_out   (out_tag_out),
    .out_final_out (out_final_out),
    .out_empty_res (out_empty_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("heap_sort_key_tag_unit_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // style 0: full range, 1: narrow range with many equal keys, 2: extreme values
  function automatic key_t pick_key(int unsigned style);
    key_t k;
    case (style)
      0: k = key_t'($urandom);
      1: k = key_t'($urandom_range(0, 8) - 4);
      default: begin
        case ($urandom_range(0, 4))
          0:       k = KEY_MIN;
          1:       k = KEY_MAX;
          2:       k = '0;
          3:       k = -1;
          default: k = 1;
        endcase
      end
    endcase
    return k;
  endfunction

  task automatic send_item(input logic mode, input key_t key, input tag_t tag, input logic fin);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_key_in     <= key;
    in_tag_in     <= tag;
    in_final_load <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_item(mode, key, tag, fin);
    if (mode == MODE_LOAD) load_count++;
    else read_count++;
  endtask

  // read payload fields are don't-care; fill them with noise
  task automatic send_reads(input int unsigned n);
    repeat (n) send_item(MODE_READ, key_t'($urandom), tag_t'($urandom),
                         1'($urandom_range(0, 1)));
  endtask

  initial begin : result_sink
    pair_result_t got;
    int unsigned  gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.key   = out_key_out;
      got.tag   = out_tag_out;
      got.last  = out_final_out;
      got.empty = out_empty_res;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned style;
    int          nreads;
    int unsigned start_items;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // read before anything was sorted
    send_reads(1);
    // a set of one pair stays as it is; second read runs past the end
    send_item(MODE_LOAD, KEY_MIN, 16'hFFFF, 1'b1);
    send_reads(2);
    // extremes and equal keys with distinct tags
    send_item(MODE_LOAD, KEY_MAX, 16'h0000, 1'b0);
    send_item(MODE_LOAD, KEY_MIN, 16'hFFFF, 1'b0);
    send_item(MODE_LOAD, '0,      16'h0001, 1'b0);
    send_item(MODE_LOAD, -1,      16'h0002, 1'b0);
    send_item(MODE_LOAD, '0,      16'h0003, 1'b0);
    send_item(MODE_LOAD, KEY_MAX, 16'h0004, 1'b1);
    send_reads(7);
    // partial read, then a load opens a new set; read before its sort is empty
    send_item(MODE_LOAD, 32'sd5, 16'hA5A5, 1'b0);
    send_item(MODE_LOAD, -32'sd5, 16'h5A5A, 1'b1);
    send_reads(1);
    send_item(MODE_LOAD, 32'sd17, 16'h1234, 1'b0);
    send_reads(1);
    send_item(MODE_LOAD, -32'sd17, 16'h4321, 1'b1);
    send_reads(3);

    // one larger set so the heap gets several levels deep
    for (int i = 0; i < BIG_SET; i++)
      send_item(MODE_LOAD, pick_key($urandom_range(0, 2)), tag_t'($urandom),
                i == BIG_SET - 1);
    send_reads(BIG_SET + 1);

    start_items = load_count + read_count;
    while (load_count + read_count < start_items + RANDOM_ITEMS) begin
      in_burst  = ($urandom_range(0, 4) == 0);
      out_burst = ($urandom_range(0, 4) == 0);
      n     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      style = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        // occasional stray read in the middle of a set
        if ($urandom_range(0, 24) == 0) send_reads(1);
        send_item(MODE_LOAD, pick_key(style), tag_t'($urandom), i == n - 1);
      end
      nreads = int'(n) + int'($urandom_range(0, 4)) - 2;
      if (nreads > 0) send_reads(nreads);
    end
    send_reads(1);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d loads and %0d reads over %0d sorted sets, largest %0d pairs",
             load_count, read_count, sb.sorts, BIG_SET);
    $display("%0d results checked, %0d of them empty, %0d mismatches",
             sb.checked, sb.empties, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("heap_sort_key_tag_unit_tb: done, clean");
    end else begin
      $display("heap_sort_key_tag_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
